>>> design/wifi_station_discovery_table_unit_defines.svh
// Assertion macros for the station discovery table checker.
`ifndef WIFI_STATION_DISCOVERY_TABLE_UNIT_DEFINES_SVH
`define WIFI_STATION_DISCOVERY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WSDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("station table check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WSDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("station table check failed");

`endif

>>> design/wsdt_pkg.sv
// Types and constants shared by the station discovery table modules.
package wsdt_pkg;

  typedef enum logic [1:0] {
    FN_FRAME        = 2'd0,
    FN_CLEAR_TABLE  = 2'd1,
    FN_READ         = 2'd2,
    FN_CLEAR_DEAUTH = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_WRONG_KIND = 4'd0,
    ST_FULL       = 4'd1,
    ST_SHORT      = 4'd2,
    ST_DEAUTH     = 4'd3,
    ST_NO_DIR     = 4'd4,
    ST_GROUP      = 4'd5,
    ST_DUPLICATE  = 4'd6,
    ST_ADDED      = 4'd7,
    ST_DONE       = 4'd8,
    ST_BAD_INDEX  = 4'd9
  } status_t;

  localparam logic [1:0]  KIND_MGMT        = 2'd0;
  localparam logic [1:0]  KIND_DATA        = 2'd2;
  localparam logic [11:0] MIN_FRAME_BYTES  = 12'd24;
  localparam logic [1:0]  FTYPE_MGMT       = 2'd0;
  localparam logic [3:0]  SUBTYPE_DEAUTH   = 4'hC;
  localparam logic [3:0]  SUBTYPE_DISASSOC = 4'hA;
  localparam int          GROUP_BIT        = 40;

  typedef struct packed {
    logic [47:0]       station;
    logic [47:0]       bssid;
    logic signed [7:0] rssi;
  } entry_t;

  typedef struct packed {
    logic    capture;
    logic    read_entry;
    logic    scan_start;
    logic    scan_step;
    logic    load_out;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    func_t   func;
    logic    pre_reject;
    status_t pre_status;
    logic    bad_index;
    logic    scan_hit;
    logic    scan_done;
    logic    out_free;
  } stat_t;

endpackage

>>> design/wsdt_datapath.sv
// Datapath: input capture, frame classification, entry memory, scan and result register.
module wsdt_datapath #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wsdt_pkg::cmd_t      cmd,
  output wsdt_pkg::stat_t     stat,
  input  logic [1:0]          in_func,
  input  logic [1:0]          in_packet_kind,
  input  logic [11:0]         in_frame_length,
  input  logic [7:0]          in_frame_control_low,
  input  logic [7:0]          in_frame_control_high,
  input  logic [47:0]         in_first_address,
  input  logic [47:0]         in_second_address,
  input  logic signed [7:0]   in_signal_strength,
  input  logic [6:0]          in_read_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_status,
  output logic [31:0]         out_deauth_total,
  output logic [7:0]          out_entry_count,
  output logic [6:0]          out_entry_index,
  output logic [47:0]         out_station_mac,
  output logic [47:0]         out_ap_bssid,
  output logic signed [7:0]   out_entry_rssi
);
  import wsdt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = (CW > 7) ? CW + 1 : 8;

  entry_t              mem [TABLE_DEPTH];
  entry_t              rd_data_r;

  func_t               func_r;
  logic [1:0]          kind_r;
  logic [11:0]         len_r;
  logic [7:0]          fcl_r;
  logic [7:0]          fch_r;
  logic [47:0]         addr1_r;
  logic [47:0]         addr2_r;
  logic signed [7:0]   rssi_r;
  logic [6:0]          read_index_r;

  logic [CW-1:0]       total_r;
  logic [CW-1:0]       total_nxt;
  logic [31:0]         deauth_r;
  logic [31:0]         deauth_nxt;
  logic [CW-1:0]       scan_ptr_r;
  logic                cmp_valid_r;
  logic                out_valid_r;

  status_t             out_status_r;
  logic [31:0]         out_deauth_r;
  logic [7:0]          out_count_r;
  logic [6:0]          out_index_r;
  entry_t              out_entry_r;

  logic [47:0]         sta;
  logic [47:0]         bss;
  logic                to_ds;
  logic                from_ds;
  logic                is_deauth;
  logic                pre_reject;
  status_t             pre_status;
  logic                bad_index;
  logic                scan_done;
  logic                scan_hit;
  logic                scan_rd;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic                out_free;
  logic [6:0]          res_index;
  entry_t              res_entry;

  assign to_ds     = fch_r[0];
  assign from_ds   = fch_r[1];
  assign sta       = to_ds ? addr2_r : addr1_r;
  assign bss       = to_ds ? addr1_r : addr2_r;
  assign is_deauth = (fcl_r[3:2] == FTYPE_MGMT) &&
                     ((fcl_r[7:4] == SUBTYPE_DEAUTH) || (fcl_r[7:4] == SUBTYPE_DISASSOC));

  always_comb begin
    pre_reject = 1'b1;
    pre_status = ST_WRONG_KIND;
    if ((kind_r != KIND_MGMT) && (kind_r != KIND_DATA)) begin
      pre_status = ST_WRONG_KIND;
    end else if (WW'(total_r) >= WW'(TABLE_DEPTH)) begin
      pre_status = ST_FULL;
    end else if (len_r < MIN_FRAME_BYTES) begin
      pre_status = ST_SHORT;
    end else if (is_deauth) begin
      pre_status = ST_DEAUTH;
    end else if (to_ds == from_ds) begin
      pre_status = ST_NO_DIR;
    end else if (sta[GROUP_BIT]) begin
      pre_status = ST_GROUP;
    end else begin
      pre_reject = 1'b0;
    end
  end

  assign scan_hit  = cmp_valid_r && (rd_data_r.station == sta) && (rd_data_r.bssid == bss);
  assign scan_rd   = cmd.scan_step && !scan_hit && (scan_ptr_r < total_r);
  assign rd_en     = cmd.read_entry || scan_rd;
  assign rd_addr   = cmd.read_entry ? AW'(read_index_r) : scan_ptr_r[AW-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign wr_en     = cmd.load_out && (cmd.res_status == ST_ADDED);
  assign bad_index = WW'(read_index_r) >= WW'(total_r);
  assign scan_done = !cmp_valid_r && (scan_ptr_r >= total_r);

  assign stat = '{func: func_r, pre_reject: pre_reject, pre_status: pre_status,
                  bad_index: bad_index, scan_hit: scan_hit, scan_done: scan_done,
                  out_free: out_free};

  always_comb begin
    total_nxt  = total_r;
    deauth_nxt = deauth_r;
    res_index  = '0;
    res_entry  = '0;
    if (cmd.res_status == ST_ADDED) begin
      total_nxt = total_r + CW'(1);
      res_index = 7'(total_r);
      res_entry = '{station: sta, bssid: bss, rssi: rssi_r};
    end else if (cmd.res_status == ST_DEAUTH) begin
      deauth_nxt = deauth_r + 32'd1;
    end else if (cmd.res_status == ST_DONE) begin
      case (func_r)
        FN_CLEAR_TABLE: total_nxt = '0;
        FN_CLEAR_DEAUTH: deauth_nxt = '0;
        FN_READ: begin
          res_index = read_index_r;
          res_entry = rd_data_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[total_r[AW-1:0]] <= '{station: sta, bssid: bss, rssi: rssi_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r       <= func_t'(in_func);
      kind_r       <= in_packet_kind;
      len_r        <= in_frame_length;
      fcl_r        <= in_frame_control_low;
      fch_r        <= in_frame_control_high;
      addr1_r      <= in_first_address;
      addr2_r      <= in_second_address;
      rssi_r       <= in_signal_strength;
      read_index_r <= in_read_index;
    end
    if (cmd.load_out) begin
      out_status_r <= cmd.res_status;
      out_deauth_r <= deauth_nxt;
      out_count_r  <= 8'(total_nxt);
      out_index_r  <= res_index;
      out_entry_r  <= res_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      deauth_r    <= '0;
      scan_ptr_r  <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        total_r  <= total_nxt;
        deauth_r <= deauth_nxt;
      end
      if (cmd.scan_start) begin
        scan_ptr_r  <= '0;
        cmp_valid_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_rd) begin
          scan_ptr_r <= scan_ptr_r + CW'(1);
        end
        cmp_valid_r <= scan_rd;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_deauth_total = out_deauth_r;
  assign out_entry_count  = out_count_r;
  assign out_entry_index  = out_index_r;
  assign out_station_mac  = out_entry_r.station;
  assign out_ap_bssid     = out_entry_r.bssid;
  assign out_entry_rssi   = out_entry_r.rssi;

endmodule

>>> design/wsdt_ctrl.sv
// Controller state machine that sequences decode, duplicate scan and result transfer.
module wsdt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wsdt_pkg::stat_t stat,
  output wsdt_pkg::cmd_t  cmd
);
  import wsdt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  status_t res_r;
  status_t res_nxt;

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.res_status = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        case (stat.func)
          FN_FRAME: begin
            if (stat.pre_reject) begin
              res_nxt = stat.pre_status;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          FN_READ: begin
            if (stat.bad_index) begin
              res_nxt = ST_BAD_INDEX;
            end else begin
              cmd.read_entry = 1'b1;
              res_nxt        = ST_DONE;
            end
          end
          default: res_nxt = ST_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          res_nxt   = ST_DUPLICATE;
          state_nxt = S_FINISH;
        end else if (stat.scan_done) begin
          res_nxt   = ST_ADDED;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> design/wifi_station_discovery_table_unit.sv
// Top level of the station discovery table: controller and datapath.
//
//   Channel   Direction  Handshake            Carries
//   in_       input      in_valid/in_stall    one frame header or table operation
//   out_      output     out_valid/out_stall  one status result per input transfer
//
// A frame that reaches the duplicate search has the entries held scanned, one entry a cycle,
// through the single read port of the entry memory; a duplicate ends the scan early.
// Every other transfer goes from decode straight to the finish state; in both cases the
// result is loaded from the finish state once the output register is free.
// The next input transfer is taken in the cycle after a result is loaded, even while it waits.
// Reset clears the entry count and deauth counter; the entry memory is not cleared.
module wifi_station_discovery_table_unit #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [1:0]        in_packet_kind,
  input  logic [11:0]       in_frame_length,
  input  logic [7:0]        in_frame_control_low,
  input  logic [7:0]        in_frame_control_high,
  input  logic [47:0]       in_first_address,
  input  logic [47:0]       in_second_address,
  input  logic signed [7:0] in_signal_strength,
  input  logic [6:0]        in_read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_status,
  output logic [31:0]       out_deauth_total,
  output logic [7:0]        out_entry_count,
  output logic [6:0]        out_entry_index,
  output logic [47:0]       out_station_mac,
  output logic [47:0]       out_ap_bssid,
  output logic signed [7:0] out_entry_rssi
);
  import wsdt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  wsdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  wsdt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_func               (in_func),
    .in_packet_kind        (in_packet_kind),
    .in_frame_length       (in_frame_length),
    .in_frame_control_low  (in_frame_control_low),
    .in_frame_control_high (in_frame_control_high),
    .in_first_address      (in_first_address),
    .in_second_address     (in_second_address),
    .in_signal_strength    (in_signal_strength),
    .in_read_index         (in_read_index),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_deauth_total      (out_deauth_total),
    .out_entry_count       (out_entry_count),
    .out_entry_index       (out_entry_index),
    .out_station_mac       (out_station_mac),
    .out_ap_bssid          (out_ap_bssid),
    .out_entry_rssi        (out_entry_rssi)
  );

endmodule

>>> design/wsdt_checker.sv
// Port-level assertion checker for the station discovery table, bound to the top level.
`include "wifi_station_discovery_table_unit_defines.svh"

module wsdt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [3:0]        out_status,
  input logic [31:0]       out_deauth_total,
  input logic [7:0]        out_entry_count,
  input logic [6:0]        out_entry_index,
  input logic [47:0]       out_station_mac,
  input logic [47:0]       out_ap_bssid,
  input logic signed [7:0] out_entry_rssi
);
  import wsdt_pkg::*;

  `WSDT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_deauth_total) && $stable(out_entry_count) && $stable(out_station_mac))
  `WSDT_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
  `WSDT_ASSERT_NOW(a_zero_fields, out_valid && (out_status != ST_ADDED) && (out_status != ST_DONE), (out_entry_index == 7'd0) && (out_station_mac == 48'd0) && (out_ap_bssid == 48'd0) && (out_entry_rssi == 8'sd0))
  `WSDT_ASSERT_NOW(a_added_unicast, out_valid && (out_status == ST_ADDED), !out_station_mac[GROUP_BIT])

endmodule

bind wifi_station_discovery_table_unit wsdt_checker u_wsdt_checker (.*);

>>> tb/sv/wsdt_result_checker.sv
// Checker that predicts and compares every result of the station discovery table.
module wsdt_result_checker #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [1:0]        in_packet_kind,
  input  logic [11:0]       in_frame_length,
  input  logic [7:0]        in_frame_control_low,
  input  logic [7:0]        in_frame_control_high,
  input  logic [47:0]       in_first_address,
  input  logic [47:0]       in_second_address,
  input  logic signed [7:0] in_signal_strength,
  input  logic [6:0]        in_read_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [3:0]        out_status,
  input  logic [31:0]       out_deauth_total,
  input  logic [7:0]        out_entry_count,
  input  logic [6:0]        out_entry_index,
  input  logic [47:0]       out_station_mac,
  input  logic [47:0]       out_ap_bssid,
  input  logic signed [7:0] out_entry_rssi,
  output int                fail_count,
  output int                pending
);
  import wsdt_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef struct packed {
    status_t           status;
    logic [31:0]       deauth_total;
    logic [7:0]        entry_count;
    logic [6:0]        entry_index;
    logic [47:0]       station_mac;
    logic [47:0]       ap_bssid;
    logic signed [7:0] entry_rssi;
  } result_t;

  entry_t      learned_pairs [TABLE_DEPTH];
  int          table_fill = 0;
  logic [31:0] deauth_count = '0;
  result_t     expected_results [$];
  result_t     oldest;
  result_t     fresh;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic learn_from_transfer(
    input  func_t             fn,
    input  logic [1:0]        kind,
    input  logic [11:0]       len,
    input  logic [7:0]        fcl,
    input  logic [7:0]        fch,
    input  logic [47:0]       addr_one,
    input  logic [47:0]       addr_two,
    input  logic signed [7:0] rssi,
    input  logic [6:0]        idx,
    output result_t           r
  );
    logic [47:0] sta;
    logic [47:0] bss;
    bit          seen;
    r = '0;
    r.status = ST_DONE;
    case (fn)
      FN_FRAME: begin
        if (kind != KIND_MGMT && kind != KIND_DATA) begin
          r.status = ST_WRONG_KIND;
        end else if (table_fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (len < MIN_FRAME_BYTES) begin
          r.status = ST_SHORT;
        end else if (fcl[3:2] == FTYPE_MGMT &&
                     (fcl[7:4] == SUBTYPE_DEAUTH || fcl[7:4] == SUBTYPE_DISASSOC)) begin
          deauth_count = deauth_count + 32'd1;
          r.status = ST_DEAUTH;
        end else if (fch[0] == fch[1]) begin
          r.status = ST_NO_DIR;
        end else begin
          sta = fch[0] ? addr_two : addr_one;
          bss = fch[0] ? addr_one : addr_two;
          if (sta[GROUP_BIT]) begin
            r.status = ST_GROUP;
          end else begin
            seen = 1'b0;
            for (int i = 0; i < table_fill; i++) begin
              if (learned_pairs[IW'(i)].station == sta && learned_pairs[IW'(i)].bssid == bss) begin
                seen = 1'b1;
              end
            end
            if (seen) begin
              r.status = ST_DUPLICATE;
            end else begin
              learned_pairs[IW'(table_fill)] = '{station: sta, bssid: bss, rssi: rssi};
              r.status = ST_ADDED;
              r.entry_index = table_fill[6:0];
              r.station_mac = sta;
              r.ap_bssid = bss;
              r.entry_rssi = rssi;
              table_fill++;
            end
          end
        end
      end
      FN_CLEAR_TABLE: begin
        table_fill = 0;
      end
      FN_READ: begin
        if (int'(idx) >= table_fill) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.entry_index = idx;
          r.station_mac = learned_pairs[IW'(idx)].station;
          r.ap_bssid = learned_pairs[IW'(idx)].bssid;
          r.entry_rssi = learned_pairs[IW'(idx)].rssi;
        end
      end
      default: begin
        deauth_count = '0;
      end
    endcase
    r.deauth_total = deauth_count;
    r.entry_count = table_fill[7:0];
  endtask

  task automatic note_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("Result field %s wrong: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      table_fill = 0;
      deauth_count = '0;
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("Result transfer with none expected: status %0d", out_status);
          end
        end else begin
          oldest = expected_results.pop_front();
          note_field("status", 64'(oldest.status), 64'(out_status));
          note_field("deauth_total", 64'(oldest.deauth_total), 64'(out_deauth_total));
          note_field("entry_count", 64'(oldest.entry_count), 64'(out_entry_count));
          note_field("entry_index", 64'(oldest.entry_index), 64'(out_entry_index));
          note_field("station_mac", 64'(oldest.station_mac), 64'(out_station_mac));
          note_field("ap_bssid", 64'(oldest.ap_bssid), 64'(out_ap_bssid));
          note_field("entry_rssi", 64'($unsigned(oldest.entry_rssi)),
                     64'($unsigned(out_entry_rssi)));
        end
      end
      if (in_valid && !in_stall) begin
        learn_from_transfer(func_t'(in_func), in_packet_kind, in_frame_length,
                            in_frame_control_low, in_frame_control_high,
                            in_first_address, in_second_address,
                            in_signal_strength, in_read_index, fresh);
        expected_results.push_back(fresh);
      end
      pending = expected_results.size();
    end
  end

endmodule

>>> tb/sv/tb_wifi_station_discovery_table_unit.sv
// Top of the station discovery table testbench: clock, reset, output stall, stimulus and verdict.
module tb_wifi_station_discovery_table_unit;
  import wsdt_pkg::*;

  localparam int          TABLE_DEPTH = 128;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          SETTLE_CYCLES = 300;
  localparam logic [1:0]  KIND_CTRL = 2'd1;
  localparam logic [1:0]  KIND_MISC = 2'd3;
  localparam logic [1:0]  FTYPE_DATA = 2'd2;
  localparam logic [7:0]  FC_DEAUTH = {SUBTYPE_DEAUTH, FTYPE_MGMT, 2'b00};
  localparam logic [7:0]  FC_DISASSOC = {SUBTYPE_DISASSOC, FTYPE_MGMT, 2'b00};
  localparam logic [7:0]  FC_BEACON = {4'h8, FTYPE_MGMT, 2'b00};
  localparam logic [7:0]  FC_DATA = {4'h0, FTYPE_DATA, 2'b00};
  localparam logic [7:0]  FC_DATA_SUB_DEAUTH = {SUBTYPE_DEAUTH, FTYPE_DATA, 2'b00};
  localparam logic [7:0]  DS_NONE = 8'h00;
  localparam logic [7:0]  DS_TO = 8'h01;
  localparam logic [7:0]  DS_FROM = 8'h02;
  localparam logic [7:0]  DS_BOTH_ALL = 8'hFF;
  localparam logic [47:0] MAC_A = 48'h0011_2233_4455;
  localparam logic [47:0] MAC_B = 48'h0200_0000_0001;
  localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MAC_UNICAST_ONES = 48'hFEFF_FFFF_FFFF;
  localparam logic [47:0] MAC_GROUP = 48'h0100_0000_0000;
  localparam int          POOL_SIZE = 8;
  localparam int          PW = $clog2(POOL_SIZE);

  typedef struct packed {
    func_t             func;
    logic [1:0]        kind;
    logic [11:0]       len;
    logic [7:0]        fcl;
    logic [7:0]        fch;
    logic [47:0]       addr_one;
    logic [47:0]       addr_two;
    logic signed [7:0] rssi;
    logic [6:0]        idx;
  } frame_req_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func = '0;
  logic [1:0]        in_packet_kind = '0;
  logic [11:0]       in_frame_length = '0;
  logic [7:0]        in_frame_control_low = '0;
  logic [7:0]        in_frame_control_high = '0;
  logic [47:0]       in_first_address = '0;
  logic [47:0]       in_second_address = '0;
  logic signed [7:0] in_signal_strength = '0;
  logic [6:0]        in_read_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        out_status;
  logic [31:0]       out_deauth_total;
  logic [7:0]        out_entry_count;
  logic [6:0]        out_entry_index;
  logic [47:0]       out_station_mac;
  logic [47:0]       out_ap_bssid;
  logic signed [7:0] out_entry_rssi;
  int                fail_count;
  int                pending;
  bit                calm = 1'b0;
  logic [47:0]       pool_station [POOL_SIZE];
  logic [47:0]       pool_bssid [POOL_SIZE];

  wifi_station_discovery_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

  wsdt_result_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_result_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** wifi_station_discovery_table_unit: FAILED **");
    $finish;
  end

  initial begin : receiver_stall
    int  run;
    bit  hold;
    forever begin
      run = $urandom_range(1, 19);
      hold = !calm && ($urandom_range(0, 2) == 0);
      repeat (run) begin
        @(negedge clk);
        out_stall <= hold;
      end
    end
  end

  function automatic logic [47:0] random_mac();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[47:0];
  endfunction

  function automatic frame_req_t frame_item(
    input logic [1:0] kind, input logic [11:0] len, input logic [7:0] fcl,
    input logic [7:0] fch, input logic [47:0] addr_one, input logic [47:0] addr_two,
    input logic signed [7:0] rssi
  );
    frame_req_t r;
    r = '0;
    r.func = FN_FRAME;
    r.kind = kind;
    r.len = len;
    r.fcl = fcl;
    r.fch = fch;
    r.addr_one = addr_one;
    r.addr_two = addr_two;
    r.rssi = rssi;
    return r;
  endfunction

  function automatic frame_req_t op_item(input func_t fn, input logic [6:0] idx);
    frame_req_t r;
    r = '0;
    r.func = fn;
    r.idx = idx;
    return r;
  endfunction

  function automatic frame_req_t random_item(input bit allow_clear);
    frame_req_t  r;
    int          pick;
    logic [PW-1:0] slot;
    logic [47:0] sta;
    logic [47:0] bss;
    pick = $urandom_range(0, 99);
    r.func = FN_FRAME;
    r.kind = 2'($urandom);
    r.len = 12'($urandom);
    r.fcl = 8'($urandom);
    r.fch = 8'($urandom);
    r.addr_one = random_mac();
    r.addr_two = random_mac();
    r.rssi = 8'($urandom);
    r.idx = 7'($urandom);
    if (pick < 65 || (pick >= 96 && !allow_clear)) begin
      r.kind = $urandom_range(0, 1) ? KIND_DATA : KIND_MGMT;
      r.len = 12'($urandom_range(24, 4095));
      if ($urandom_range(0, 9) == 0) begin
        r.fcl = $urandom_range(0, 1) ? FC_DEAUTH : FC_DISASSOC;
        r.fcl[1:0] = 2'($urandom);
      end
      r.fch[1:0] = $urandom_range(0, 1) ? 2'b01 : 2'b10;
      slot = PW'($urandom_range(0, POOL_SIZE - 1));
      if ($urandom_range(0, 3) == 0) begin
        sta = pool_station[slot];
        bss = pool_bssid[slot];
        if ($urandom_range(0, 3) == 0) begin
          bss = random_mac();
        end
      end else begin
        sta = random_mac();
        sta[GROUP_BIT] = ($urandom_range(0, 15) == 0);
        bss = random_mac();
        pool_station[slot] = sta;
        pool_bssid[slot] = bss;
      end
      r.addr_one = r.fch[0] ? bss : sta;
      r.addr_two = r.fch[0] ? sta : bss;
    end else if (pick < 80) begin
      r.func = FN_FRAME;
    end else if (pick < 92) begin
      r.func = FN_READ;
      if ($urandom_range(0, 1) == 0) begin
        r.idx = 7'($urandom_range(0, 15));
      end
    end else if (pick < 96) begin
      r.func = FN_CLEAR_DEAUTH;
    end else begin
      r.func = FN_CLEAR_TABLE;
    end
    return r;
  endfunction

  task automatic send_item(input frame_req_t r);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= r.func;
    in_packet_kind <= r.kind;
    in_frame_length <= r.len;
    in_frame_control_low <= r.fcl;
    in_frame_control_high <= r.fch;
    in_first_address <= r.addr_one;
    in_second_address <= r.addr_two;
    in_signal_strength <= r.rssi;
    in_read_index <= r.idx;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stimulus
    int n;
    for (n = 0; n < POOL_SIZE; n++) begin
      pool_station[PW'(n)] = MAC_A;
      pool_bssid[PW'(n)] = MAC_B;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(op_item(FN_READ, 7'd0));
    send_item(frame_item(KIND_CTRL, 12'd100, FC_DATA, DS_TO, MAC_B, MAC_A, 8'sd0));
    send_item(frame_item(KIND_MISC, 12'd100, FC_DATA, DS_TO, MAC_B, MAC_A, 8'sd0));
    send_item(frame_item(KIND_MGMT, 12'd23, FC_BEACON, DS_FROM, MAC_A, MAC_B, 8'sd0));
    send_item(frame_item(KIND_DATA, 12'd0, FC_DATA, DS_TO, MAC_B, MAC_A, 8'sd0));
    send_item(frame_item(KIND_MGMT, 12'd24, FC_DEAUTH, DS_NONE, MAC_A, MAC_B, 8'sd0));
    send_item(frame_item(KIND_MGMT, 12'd4095, FC_DISASSOC, DS_TO, MAC_B, MAC_A, 8'sd0));
    send_item(frame_item(KIND_DATA, 12'd64, FC_DEAUTH, DS_TO, MAC_B, MAC_A, 8'sd0));
    send_item(frame_item(KIND_DATA, 12'd64, FC_DATA_SUB_DEAUTH, DS_TO, MAC_B, MAC_A, -8'sd40));
    send_item(frame_item(KIND_MGMT, 12'd60, FC_BEACON, DS_NONE, MAC_A, MAC_B, 8'sd0));
    send_item(frame_item(KIND_MGMT, 12'd60, FC_BEACON, DS_BOTH_ALL, MAC_A, MAC_B, 8'sd0));
    send_item(frame_item(KIND_DATA, 12'd60, FC_DATA, DS_FROM, MAC_GROUP, MAC_B, 8'sd0));
    send_item(frame_item(KIND_DATA, 12'd60, FC_DATA, DS_TO, MAC_ONES, MAC_GROUP, 8'sd0));
    send_item(frame_item(KIND_DATA, 12'd60, FC_DATA, DS_TO, MAC_ONES, MAC_UNICAST_ONES,
                         -8'sd128));
    send_item(frame_item(KIND_DATA, 12'd60, FC_DATA, DS_TO, MAC_ONES, MAC_UNICAST_ONES,
                         8'sd5));
    send_item(frame_item(KIND_DATA, 12'd60, FC_DATA, DS_TO, '0, MAC_UNICAST_ONES, 8'sd127));
    send_item(frame_item(KIND_MGMT, 12'd24, FC_BEACON, DS_FROM, '0, '0, 8'sd0));
    send_item(op_item(FN_READ, 7'd0));
    send_item(op_item(FN_READ, 7'd3));
    send_item(op_item(FN_READ, 7'd4));
    send_item(op_item(FN_READ, 7'd127));
    send_item(op_item(FN_CLEAR_DEAUTH, 7'd0));
    send_item(op_item(FN_CLEAR_TABLE, 7'd0));
    send_item(op_item(FN_READ, 7'd0));
    send_item(frame_item(KIND_DATA, 12'd60, FC_DATA, DS_TO, MAC_ONES, MAC_UNICAST_ONES,
                         -8'sd128));

    for (n = 0; n < 350; n++) begin
      send_item(random_item(1'b0));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);

    for (n = 0; n < 350; n++) begin
      if (n == 250) begin
        calm = 1'b1;
      end
      send_item(random_item(1'b1));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** wifi_station_discovery_table_unit: PASSED **");
    end else begin
      $display("** wifi_station_discovery_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/wsdt_pkg.sv
design/wsdt_datapath.sv
design/wsdt_ctrl.sv
design/wifi_station_discovery_table_unit.sv
design/wsdt_checker.sv
tb/sv/wsdt_result_checker.sv
tb/sv/tb_wifi_station_discovery_table_unit.sv
